// ----- sv/wsp_pkg.sv -----
// Shared types and constants for the world-to-screen projection core.
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 64;
  localparam int OFF_W      = 66;
  localparam int DIV_STAGES = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CFG_IDX_W  = 4;

  // Mode register codes
  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_ISO    = 2'd1,
    MODE_PERSP  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // Item class decided by the front end
  typedef enum logic [1:0] {
    CLS_LINEAR = 2'd0,
    CLS_ISO    = 2'd1,
    CLS_PERSP  = 2'd2
  } cls_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 4'd0,
    CFG_FLIP     = 4'd1,
    CFG_ORIGIN_X = 4'd2,
    CFG_ORIGIN_Y = 4'd3,
    CFG_CAMERA_X = 4'd4,
    CFG_CAMERA_Y = 4'd5,
    CFG_SCALE    = 4'd6,
    CFG_TILE_H   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    mode_t                     mode;
    logic                      flip;
    logic signed [DATA_W-1:0]  org_h;
    logic signed [DATA_W-1:0]  org_v;
    logic signed [DATA_W-1:0]  cam_h;
    logic signed [DATA_W-1:0]  cam_v;
    logic signed [DATA_W-1:0]  scale;
    logic signed [DATA_W-1:0]  tile_h;
  } cfg_t;

  // Item passed from front end to back end
  typedef struct packed {
    cls_t                      cls;
    logic                      flip;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [DATA_W-1:0]  depth;
  } item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_AW:0]   count;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ----- sv/wsp_front.sv -----
// Front end: accepts points, classifies by mode, forms the scaled products.
`timescale 1ns / 1ps
`default_nettype none
module wsp_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_fire,
  input  wire logic signed [wsp_pkg::DATA_W-1:0] in_x,
  input  wire logic signed [wsp_pkg::DATA_W-1:0] in_y,
  input  wire logic signed [wsp_pkg::DATA_W-1:0] in_d,
  input  wire wsp_pkg::cfg_t                  cfg,
  output logic                                push,
  output wsp_pkg::item_t                      item
);
  import wsp_pkg::*;

  logic                       s1_vld_r;
  cls_t                       s1_cls_r, cls_nxt;
  logic                       s1_flip_r;
  logic signed [DATA_W:0]     s1_ax_r, s1_ay_r, ax_nxt, ay_nxt;
  logic signed [DATA_W-1:0]   s1_bx_r, s1_by_r, bx_nxt, by_nxt;
  logic signed [DATA_W-1:0]   s1_d_r;
  logic signed [DATA_W:0]     px, py;
  logic signed [PROD_W:0]     mul_x, mul_y;
  logic                       push_r;
  item_t                      item_r;

  assign px = {in_x[DATA_W-1], in_x};
  assign py = {in_y[DATA_W-1], in_y};

  // Classify and pick multiplier operands
  always_comb begin
    case (cfg.mode)
      MODE_ISO: begin
        cls_nxt = CLS_ISO;
        ax_nxt  = px - py;
        ay_nxt  = px + py;
        bx_nxt  = cfg.scale;
        by_nxt  = cfg.tile_h;
      end
      MODE_PERSP: begin
        cls_nxt = CLS_PERSP;
        ax_nxt  = px;
        ay_nxt  = py;
        bx_nxt  = cfg.scale;
        by_nxt  = cfg.scale;
      end
      default: begin
        cls_nxt = CLS_LINEAR;
        ax_nxt  = px - {cfg.cam_h[DATA_W-1], cfg.cam_h};
        ay_nxt  = py - {cfg.cam_v[DATA_W-1], cfg.cam_v};
        bx_nxt  = cfg.scale;
        by_nxt  = cfg.scale;
      end
    endcase
  end

  // Operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
    s1_cls_r  <= cls_nxt;
    s1_flip_r <= cfg.flip;
    s1_ax_r   <= ax_nxt;
    s1_ay_r   <= ay_nxt;
    s1_bx_r   <= bx_nxt;
    s1_by_r   <= by_nxt;
    s1_d_r    <= in_d;
  end

  // Product stage, kept to 64 bits (wraps like the 64-bit arithmetic it mirrors)
  assign mul_x = s1_ax_r * s1_bx_r;
  assign mul_y = s1_ay_r * s1_by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= s1_vld_r;
    end
    item_r.cls    <= s1_cls_r;
    item_r.flip   <= s1_flip_r;
    item_r.prod_x <= mul_x[PROD_W-1:0];
    item_r.prod_y <= mul_y[PROD_W-1:0];
    item_r.depth  <= s1_d_r;
  end

  assign push = push_r;
  assign item = item_r;

endmodule
`default_nettype wire

// ----- sv/wsp_fifo.sv -----
// Short item queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module wsp_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wsp_pkg::item_t wr_item,
  input  wire logic           pop,
  output wsp_pkg::item_t      rd_item,
  output wsp_pkg::fifo_stat_t stat
);
  import wsp_pkg::*;

  item_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r;
  logic                 do_push, do_pop;

  assign do_push = push && (count_r != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule
`default_nettype wire

// ----- sv/wsp_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module wsp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [wsp_pkg::PROD_W-1:0]  num,
  input  wire logic [wsp_pkg::DATA_W-1:0]  den,
  output logic                             out_vld,
  output logic [wsp_pkg::PROD_W-1:0]       quo
);
  import wsp_pkg::*;

  logic                vld_r [DIV_STAGES];
  logic [DATA_W-1:0]   rem_r [DIV_STAGES];
  logic [PROD_W-1:0]   wrk_r [DIV_STAGES];
  logic [DATA_W-1:0]   den_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                vld_i;
    logic [DATA_W-1:0]   rem_i, den_i, rem_nxt;
    logic [PROD_W-1:0]   wrk_i, wrk_nxt;
    logic [DATA_W:0]     trial, diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = '0;
      assign wrk_i = num;
      assign den_i = den;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign wrk_i = wrk_r[k-1];
      assign den_i = den_r[k-1];
    end

    // Shift in next dividend bit, subtract if it fits
    always_comb begin
      trial   = {rem_i, wrk_i[PROD_W-1]};
      diff    = trial - {1'b0, den_i};
      ge      = (trial >= {1'b0, den_i});
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      wrk_nxt = {wrk_i[PROD_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      rem_r[k] <= rem_nxt;
      wrk_r[k] <= wrk_nxt;
      den_r[k] <= den_i;
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign quo     = wrk_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- sv/wsp_back.sv -----
// Back end: shift or divide the products, add the origin, saturate.
`timescale 1ns / 1ps
`default_nettype none
module wsp_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire wsp_pkg::item_t                    item,
  input  wire logic signed [wsp_pkg::DATA_W-1:0] org_h,
  input  wire logic signed [wsp_pkg::DATA_W-1:0] org_v,
  output logic                                   out_valid,
  output logic signed [wsp_pkg::DATA_W-1:0]      screen_x,
  output logic signed [wsp_pkg::DATA_W-1:0]      screen_y,
  output logic                                   saturated
);
  import wsp_pkg::*;

  typedef struct packed {
    cls_t                     cls;
    logic                     flip;
    logic signed [PROD_W-1:0] shx;
    logic signed [PROD_W-1:0] shy;
    logic                     negx;
    logic                     negy;
  } side_t;

  localparam logic signed [OFF_W-1:0] SAT_MAX = OFF_W'(64'sh7FFF_FFFF);
  localparam logic signed [OFF_W-1:0] SAT_MIN = -OFF_W'(64'sh8000_0000);

  side_t               side_nxt, side0_r;
  side_t               side_r [DIV_STAGES];
  logic                vld0_r;
  logic [PROD_W-1:0]   nx_r, ny_r, nx_nxt, ny_nxt;
  logic [DATA_W-1:0]   den_r, den_nxt;
  logic signed [DATA_W-1:0] d_eff;
  logic signed [PROD_W-1:0] px, py;
  logic                dvx, dvy;
  logic [PROD_W-1:0]   qx, qy;

  assign px = $signed(item.prod_x);
  assign py = $signed(item.prod_y);

  // Entry stage: shifted offsets and divider operands
  always_comb begin
    d_eff         = (item.depth == '0) ? DATA_W'(1) : item.depth;
    side_nxt.cls  = item.cls;
    side_nxt.flip = item.flip;
    if (item.cls == CLS_ISO) begin
      side_nxt.shx = px >>> (FRAC_BITS + 1);
      side_nxt.shy = py >>> (FRAC_BITS + 1);
    end else begin
      side_nxt.shx = px >>> FRAC_BITS;
      side_nxt.shy = py >>> FRAC_BITS;
    end
    side_nxt.negx = px[PROD_W-1] ^ d_eff[DATA_W-1];
    side_nxt.negy = py[PROD_W-1] ^ d_eff[DATA_W-1];
    nx_nxt  = px[PROD_W-1] ? PROD_W'(-px) : PROD_W'(px);
    ny_nxt  = py[PROD_W-1] ? PROD_W'(-py) : PROD_W'(py);
    den_nxt = d_eff[DATA_W-1] ? DATA_W'(-d_eff) : DATA_W'(d_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
    side0_r <= side_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    den_r   <= den_nxt;
  end

  wsp_div u_div_x (
    .clk(clk), .rst_n(rst_n), .in_vld(vld0_r), .num(nx_r), .den(den_r),
    .out_vld(dvx), .quo(qx)
  );

  wsp_div u_div_y (
    .clk(clk), .rst_n(rst_n), .in_vld(vld0_r), .num(ny_r), .den(den_r),
    .out_vld(dvy), .quo(qy)
  );

  // Side data delay matched to the divider
  always_ff @(posedge clk) begin
    side_r[0] <= side0_r;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Output stage
  side_t                   sd;
  logic signed [OFF_W-1:0] offx, offy, sumx, sumy, qxs, qys;
  logic signed [DATA_W-1:0] sx_nxt, sy_nxt;
  logic                    satx, saty;
  logic                    out_valid_r, sat_r;
  logic signed [DATA_W-1:0] sx_r, sy_r;

  always_comb begin
    sd  = side_r[DIV_STAGES-1];
    qxs = $signed({2'b00, qx});
    qys = $signed({2'b00, qy});
    if (sd.cls == CLS_PERSP) begin
      offx = sd.negx ? -qxs : qxs;
      offy = sd.negy ? -qys : qys;
    end else begin
      offx = OFF_W'(sd.shx);
      offy = OFF_W'(sd.shy);
    end
    if (sd.flip && (sd.cls != CLS_ISO)) begin
      offy = -offy;
    end
    sumx = OFF_W'(org_h) + offx;
    sumy = OFF_W'(org_v) + offy;
    satx = (sumx > SAT_MAX) || (sumx < SAT_MIN);
    saty = (sumy > SAT_MAX) || (sumy < SAT_MIN);
    if (sumx > SAT_MAX)      sx_nxt = SAT_MAX[DATA_W-1:0];
    else if (sumx < SAT_MIN) sx_nxt = SAT_MIN[DATA_W-1:0];
    else                     sx_nxt = sumx[DATA_W-1:0];
    if (sumy > SAT_MAX)      sy_nxt = SAT_MAX[DATA_W-1:0];
    else if (sumy < SAT_MIN) sy_nxt = SAT_MIN[DATA_W-1:0];
    else                     sy_nxt = sumy[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvx && dvy;
    end
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    sat_r <= satx || saty;
  end

  assign out_valid = out_valid_r;
  assign screen_x  = sx_r;
  assign screen_y  = sy_r;
  assign saturated = sat_r;

endmodule
`default_nettype wire

// ----- sv/world_to_screen_projection_core.sv -----
// Top level of the world-to-screen projection core.
//
// Usage:
//   Input: drive in_point_x/y/depth and raise start; the item is taken at a
//   rising edge with start high and busy low. One point per clock if not busy.
//   Output: out_valid strobes for one cycle with out_screen_x/y and
//   out_saturated. The receiver cannot stall; results come in input order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. The user
//   must write only while the block is idle; the block does not enforce it.
//   Unknown indexes are ignored. Items in all modes pass the front-end
//   registers, the queue, the back-end entry register, the 64-stage
//   one-bit-per-stage divider that serves perspective mode, and the output
//   register. Throughput: one item per cycle while busy is low.
//   Reset (rst_n low, synchronous): pipeline and queue empty, mode linear,
//   no flip, origins and camera zero, both scales 1.0.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]    in_point_x,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]    in_point_y,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]    in_point_depth,
  output logic                                      out_valid,
  output logic signed [wsp_pkg::DATA_W-1:0]         out_screen_x,
  output logic signed [wsp_pkg::DATA_W-1:0]         out_screen_y,
  output logic                                      out_saturated,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wsp_pkg::DATA_W-1:0]           cfg_data
);
  import wsp_pkg::*;

  localparam logic [DATA_W-1:0] SCALE_ONE = DATA_W'(1) << FRAC_BITS;

  cfg_t        cfg_r;
  logic        cfg_we;
  logic        in_fire;
  logic        push, pop;
  item_t       wr_item, rd_item;
  fifo_stat_t  fstat;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_LINEAR;
      cfg_r.flip   <= 1'b0;
      cfg_r.org_h  <= '0;
      cfg_r.org_v  <= '0;
      cfg_r.cam_h  <= '0;
      cfg_r.cam_v  <= '0;
      cfg_r.scale  <= SCALE_ONE;
      cfg_r.tile_h <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:     cfg_r.mode   <= mode_t'(cfg_data[1:0]);
        CFG_FLIP:     cfg_r.flip   <= cfg_data[0];
        CFG_ORIGIN_X: cfg_r.org_h  <= cfg_data;
        CFG_ORIGIN_Y: cfg_r.org_v  <= cfg_data;
        CFG_CAMERA_X: cfg_r.cam_h  <= cfg_data;
        CFG_CAMERA_Y: cfg_r.cam_v  <= cfg_data;
        CFG_SCALE:    cfg_r.scale  <= cfg_data;
        CFG_TILE_H:   cfg_r.tile_h <= cfg_data;
        default:      cfg_r        <= cfg_r;
      endcase
    end
  end

  // Hold off only when the queue could not absorb items already in the front end
  assign busy    = (fstat.count > (FIFO_AW+1)'(FIFO_DEPTH - 3));
  assign in_fire = start && !busy;

  wsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_x(in_point_x), .in_y(in_point_y), .in_d(in_point_depth),
    .cfg(cfg_r), .push(push), .item(wr_item)
  );

  assign pop = !fstat.empty;

  wsp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_item(wr_item),
    .pop(pop), .rd_item(rd_item), .stat(fstat)
  );

  wsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(pop), .item(rd_item),
    .org_h(cfg_r.org_h), .org_v(cfg_r.org_v),
    .out_valid(out_valid), .screen_x(out_screen_x), .screen_y(out_screen_y),
    .saturated(out_saturated)
  );

`ifndef ASSERT_OFF
  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fstat.full))
    else $error("item queue overflow");

  // A saturated result sits on a range limit
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_screen_x == 32'sh7FFF_FFFF || out_screen_x == 32'sh8000_0000 ||
       out_screen_y == 32'sh7FFF_FFFF || out_screen_y == 32'sh8000_0000))
    else $error("saturation flag without clipped coordinate");

  // Block is free right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or output after reset");
`endif

endmodule
`default_nettype wire

// ----- dv/world_to_screen_projection_core_test.sv -----
// Testbench for the world-to-screen projection core: directed table plus random phases.
`timescale 1ns / 1ps
module world_to_screen_projection_core_test;
  import wsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] BAD_IDX = 4'd9;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } screen_pt_t;

  typedef enum logic { ROW_CFG, ROW_POINT } row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]         data;
    logic [31:0]         px, py, pd;
    logic                has_exp;
    screen_pt_t          exp;
  } stim_row_t;

  typedef struct {
    int         seq;
    screen_pt_t pt;
  } typed_exp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_point_x = 0, in_point_y = 0, in_point_depth = 0;
  logic out_valid;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic out_saturated;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  // Shadow copy of the configuration registers
  mode_t              sh_mode;
  logic               sh_flip;
  logic signed [31:0] sh_ox, sh_oy, sh_cx, sh_cy, sh_scale, sh_tile_h;

  screen_pt_t screen_q[$];
  typed_exp_t typed_q[$];
  int accepted_cnt = 0;
  int result_cnt = 0;
  bit failed = 0;
  int burst_left = 0;

  world_to_screen_projection_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_depth(in_point_depth),
    .out_valid(out_valid), .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Clip a wide sum to 32 bits, flagging any clipping
  function automatic logic signed [31:0] clip_coord(logic signed [95:0] v, ref logic sat);
    if (v > 96'sh7FFF_FFFF) begin
      sat = 1;
      return S_MAX;
    end
    if (v < -96'sh8000_0000) begin
      sat = 1;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  // Products live in 64 bits and wrap there
  function automatic logic signed [95:0] wrap64(logic signed [95:0] v);
    logic signed [63:0] w;
    w = v[63:0];
    return 96'(w);
  endfunction

  // Expected screen point for one world point under the shadow config
  function automatic screen_pt_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                               logic signed [31:0] pd);
    logic signed [95:0] wx, wy, wd, sc, th, offx, offy;
    screen_pt_t r;
    logic sat;
    wx = px;
    wy = py;
    wd = pd;
    sc = sh_scale;
    th = sh_tile_h;
    sat = 0;
    case (sh_mode)
      MODE_ISO: begin
        offx = wrap64((wx - wy) * sc) >>> 17;
        offy = wrap64((wx + wy) * th) >>> 17;
      end
      MODE_PERSP: begin
        if (wd == 0) wd = 1;
        offx = wrap64(wx * sc) / wd;
        offy = wrap64(wy * sc) / wd;
        if (sh_flip) offy = -offy;
      end
      default: begin
        offx = wrap64((wx - 96'(sh_cx)) * sc) >>> 16;
        offy = wrap64((wy - 96'(sh_cy)) * sc) >>> 16;
        if (sh_flip) offy = -offy;
      end
    endcase
    r.x = clip_coord(96'(sh_ox) + offx, sat);
    r.y = clip_coord(96'(sh_oy) + offy, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic void report_mismatch(string what, screen_pt_t e);
    $display("%0t mismatch (%s): expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b", $time,
             what, e.x, e.y, e.sat, out_screen_x, out_screen_y, out_saturated);
    failed = 1;
  endfunction

  // Sample at the falling edge: values here are the ones the next rising edge sees
  always @(negedge clk) begin
    screen_pt_t e;
    typed_exp_t t;
    if (rst_n) begin
      if (out_valid) begin
        if (screen_q.size() == 0) begin
          $display("%0t unexpected item: x=%h y=%h sat=%b", $time, out_screen_x,
                   out_screen_y, out_saturated);
          failed = 1;
        end else begin
          e = screen_q.pop_front();
          if (out_screen_x !== e.x || out_screen_y !== e.y || out_saturated !== e.sat)
            report_mismatch("predicted", e);
          if (typed_q.size() > 0 && typed_q[0].seq == result_cnt) begin
            t = typed_q.pop_front();
            if (out_screen_x !== t.pt.x || out_screen_y !== t.pt.y ||
                out_saturated !== t.pt.sat)
              report_mismatch("table", t.pt);
          end
        end
        result_cnt++;
      end
      if (start && !busy) begin
        screen_q.push_back(project_point(in_point_x, in_point_y, in_point_depth));
        accepted_cnt++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:     sh_mode = mode_t'(cfg_data[1:0]);
          CFG_FLIP:     sh_flip = cfg_data[0];
          CFG_ORIGIN_X: sh_ox = cfg_data;
          CFG_ORIGIN_Y: sh_oy = cfg_data;
          CFG_CAMERA_X: sh_cx = cfg_data;
          CFG_CAMERA_Y: sh_cy = cfg_data;
          CFG_SCALE:    sh_scale = cfg_data;
          CFG_TILE_H:   sh_tile_h = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Wait until every expected item is out, then let the pipeline settle
  task automatic drain_results();
    while (screen_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    bit ok;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Send one point, keeping start high inside a burst
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pd);
    bit ok;
    start <= 1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_depth <= pd;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      3: return 32'($urandom_range(0, 4));
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      2: return 32'($urandom_range(0, 1) ? 0 : -1);
      default: return {{13{$urandom_range(0, 1) == 1}}, 19'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom();
      2: return 32'($urandom_range(0, 1) ? 1 : -1);
      default: return {{10{$urandom_range(0, 1) == 1}}, 22'($urandom())};
    endcase
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [31:0] data);
    stim_row_t r;
    r = '{ROW_CFG, idx, data, 0, 0, 0, 0, '0};
    return r;
  endfunction

  function automatic stim_row_t pt_row(logic [31:0] px, logic [31:0] py, logic [31:0] pd,
                                       logic has_exp, logic [31:0] ex, logic [31:0] ey,
                                       logic es);
    stim_row_t r;
    r = '{ROW_POINT, CFG_MODE, 0, px, py, pd, has_exp, '{ex, ey, es}};
    return r;
  endfunction

  initial begin
    #50_000_000;
    $display("** world_to_screen_projection_core: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    typed_exp_t t;
    int n;

    sh_mode = MODE_LINEAR;
    sh_flip = 0;
    sh_ox = 0;
    sh_oy = 0;
    sh_cx = 0;
    sh_cy = 0;
    sh_scale = Q_ONE;
    sh_tile_h = Q_ONE;

    // Directed table: values after reset first, then each mode and corner
    rows.push_back(pt_row(0, 0, 0, 1, 0, 0, 0));
    rows.push_back(pt_row(S_MAX, S_MIN, 5, 1, S_MAX, S_MIN, 0));
    rows.push_back(pt_row(32'h0001_8000, 32'hFFFF_8000, 0, 1, 32'h0001_8000,
                          32'hFFFF_8000, 0));
    rows.push_back(cfg_row(CFG_ORIGIN_X, S_MAX));
    rows.push_back(pt_row(Q_ONE, 0, 0, 1, S_MAX, 0, 1));
    rows.push_back(cfg_row(CFG_ORIGIN_X, S_MIN));
    rows.push_back(pt_row(32'hFFFF_0000, 0, 0, 1, S_MIN, 0, 1));
    rows.push_back(cfg_row(CFG_ORIGIN_X, 0));
    rows.push_back(cfg_row(CFG_CAMERA_X, Q_ONE));
    rows.push_back(cfg_row(CFG_CAMERA_Y, 32'hFFFF_0000));
    rows.push_back(cfg_row(CFG_SCALE, 32'h0002_0000));
    rows.push_back(pt_row(Q_ONE, 0, 0, 1, 0, 32'h0002_0000, 0));
    rows.push_back(pt_row(S_MIN, S_MAX, 0, 0, 0, 0, 0));
    rows.push_back(cfg_row(CFG_FLIP, 1));
    rows.push_back(pt_row(Q_ONE, 0, 0, 1, 0, 32'hFFFE_0000, 0));
    // unused mode code behaves as linear
    rows.push_back(cfg_row(CFG_MODE, MODE_UNUSED));
    rows.push_back(pt_row(Q_ONE, 0, 0, 1, 0, 32'hFFFE_0000, 0));
    rows.push_back(cfg_row(CFG_MODE, MODE_ISO));
    rows.push_back(pt_row(Q_ONE, Q_ONE, 0, 1, 0, Q_ONE, 0));
    rows.push_back(pt_row(32'hFFFF_FFFF, 32'h0000_0002, 0, 0, 0, 0, 0));
    rows.push_back(pt_row(S_MIN, S_MAX, 0, 0, 0, 0, 0));
    rows.push_back(cfg_row(CFG_MODE, MODE_PERSP));
    rows.push_back(cfg_row(CFG_SCALE, Q_ONE));
    // zero depth taken as one LSB: both axes clip
    rows.push_back(pt_row(Q_ONE, 32'h0002_0000, 0, 1, S_MAX, S_MIN, 1));
    rows.push_back(pt_row(Q_ONE, Q_ONE, 32'h0002_0000, 1, 32'h0000_8000, 32'hFFFF_8000, 0));
    rows.push_back(pt_row(32'hFFFF_FFFD, 5, 32'hFFFE_0000, 0, 0, 0, 0));
    rows.push_back(pt_row(S_MIN, S_MIN, 32'hFFFF_FFFF, 0, 0, 0, 0));
    // write to an unknown index is ignored
    rows.push_back('{ROW_CFG, BAD_IDX, 32'hDEAD_BEEF, 0, 0, 0, 0, '0});
    rows.push_back(cfg_row(CFG_TILE_H, S_MIN));
    rows.push_back(cfg_row(CFG_ORIGIN_Y, S_MAX));
    rows.push_back(pt_row(Q_ONE, Q_ONE, 32'h0002_0000, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CFG) begin
        start <= 0;
        burst_left = 0;
        drain_results();
        write_reg(r.idx, r.data);
      end else begin
        if (r.has_exp) begin
          t.seq = accepted_cnt;
          t.pt = r.exp;
          typed_q.push_back(t);
        end
        send_point(r.px, r.py, r.pd);
      end
    end

    // Random phases, each with a fresh configuration
    for (int ph = 0; ph < 13; ph++) begin
      start <= 0;
      burst_left = 0;
      drain_results();
      write_reg(CFG_MODE, ph < 4 ? 32'(ph) : 32'($urandom_range(0, 3)));
      write_reg(CFG_FLIP, $urandom_range(0, 1));
      write_reg(CFG_ORIGIN_X, rand_coord());
      write_reg(CFG_ORIGIN_Y, rand_coord());
      write_reg(CFG_CAMERA_X, rand_coord());
      write_reg(CFG_CAMERA_Y, rand_coord());
      write_reg(CFG_SCALE, ph == 5 ? S_MIN : ph == 6 ? S_MAX : rand_scale());
      write_reg(CFG_TILE_H, ph == 5 ? S_MAX : rand_scale());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom());
      n = $urandom_range(90, 130);
      for (int k = 0; k < n; k++) begin
        send_point(rand_coord(), rand_coord(), rand_depth());
        // one pause mid-phase until the pipeline is empty
        if (ph == 7 && k == n / 2) begin
          start <= 0;
          burst_left = 0;
          while (screen_q.size() != 0) @(posedge clk);
        end
      end
    end

    start <= 0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (typed_q.size() != 0) begin
      $display("%0t table expectations left over: %0d", $time, typed_q.size());
      failed = 1;
    end
    if (!failed)
      $display("** world_to_screen_projection_core: PASSED **");
    else
      $display("** world_to_screen_projection_core: FAILED **");
    $finish;
  end

endmodule
